### hdl/silc_pkg.sv
// Shared types, character codes and sizes for the SQL IN-list collapser.
// Used by silc_step, silc_fifo and sql_in_list_collapser_unit; depends on nothing.
package silc_pkg;

  localparam int NEST_WIDTH_DEF = 8;

  localparam int PATTERN_LEN = 5;
  localparam int PROG_W      = 3;

  localparam logic [7:0] CH_ANY_MARK = 8'h3F;
  localparam logic [7:0] CH_N        = 8'h4E;
  localparam logic [7:0] CH_CLOSE    = 8'h29;
  localparam logic [7:0] CH_OPEN     = 8'h28;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_I        = 8'h69;
  localparam logic [7:0] CH_LOWER_N  = 8'h6E;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_item_t;

  // Up to two result characters produced by one input character.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
  } step_out_t;

  // Characters of the pattern " in (" by position.
  function automatic logic [7:0] pattern_char(input logic [PROG_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_SPACE;
      3'd1:    c = CH_I;
      3'd2:    c = CH_LOWER_N;
      3'd3:    c = CH_SPACE;
      3'd4:    c = CH_OPEN;
      default: c = CH_SPACE;
    endcase
    return c;
  endfunction

endpackage

### hdl/silc_step.sv
// Per-character rewrite step: pattern matcher, list skipping and nesting count.
// Holds the matcher state registers; depends on silc_pkg.
module silc_step #(
  parameter int NEST_WIDTH = silc_pkg::NEST_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  silc_pkg::in_item_t   item,
  output silc_pkg::step_out_t  result
);

  logic [silc_pkg::PROG_W-1:0] match_progress, match_progress_next;
  logic                        list_pending, list_pending_next;
  logic                        skipping, skipping_next;
  logic [NEST_WIDTH-1:0]       nest_count, nest_count_next;

  logic [7:0]                  c;
  logic                        last;
  logic [silc_pkg::PROG_W-1:0] p;

  assign c    = item.in_char;
  assign last = item.in_last;

  always_comb begin
    match_progress_next = match_progress;
    list_pending_next   = list_pending;
    skipping_next       = skipping;
    nest_count_next     = nest_count;
    result.count        = 2'd0;
    result.res0         = '{out_char: silc_pkg::CH_N, out_last: 1'b0};
    result.res1         = '{out_char: silc_pkg::CH_CLOSE, out_last: last};
    p                   = match_progress;
    if (p >= silc_pkg::PROG_W'(silc_pkg::PATTERN_LEN)) begin
      p = '0;
    end

    if (skipping) begin
      if (c == silc_pkg::CH_OPEN) begin
        if (!(&nest_count)) begin
          nest_count_next = nest_count + NEST_WIDTH'(1);
        end
      end else if (c == silc_pkg::CH_CLOSE) begin
        if (nest_count == '0) begin
          skipping_next = 1'b0;
          result.count  = 2'd2;
        end else begin
          nest_count_next = nest_count - NEST_WIDTH'(1);
        end
      end
      // A query that ends inside the list still gets its "N)".
      if (last) begin
        result.count = 2'd2;
      end
    end else if (list_pending && c == silc_pkg::CH_ANY_MARK) begin
      list_pending_next = 1'b0;
      skipping_next     = 1'b1;
      nest_count_next   = '0;
      if (last) begin
        result.count = 2'd2;
      end
    end else begin
      list_pending_next = 1'b0;
      result.count      = 2'd1;
      result.res0       = '{out_char: c, out_last: last};
      if (c == silc_pkg::pattern_char(p)) begin
        if (p == silc_pkg::PROG_W'(silc_pkg::PATTERN_LEN - 1)) begin
          list_pending_next   = 1'b1;
          match_progress_next = '0;
        end else begin
          match_progress_next = p + silc_pkg::PROG_W'(1);
        end
      end else begin
        // A mismatching space can still start a new pattern.
        match_progress_next = (c == silc_pkg::CH_SPACE) ? silc_pkg::PROG_W'(1) : '0;
      end
    end

    if (last) begin
      match_progress_next = '0;
      list_pending_next   = 1'b0;
      skipping_next       = 1'b0;
      nest_count_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_progress <= '0;
      list_pending   <= 1'b0;
      skipping       <= 1'b0;
      nest_count     <= '0;
    end else if (accept) begin
      match_progress <= match_progress_next;
      list_pending   <= list_pending_next;
      skipping       <= skipping_next;
      nest_count     <= nest_count_next;
    end
  end

`ifndef SYNTHESIS
  a_progress_range: assert property (@(posedge clk) disable iff (rst)
    match_progress < silc_pkg::PROG_W'(silc_pkg::PATTERN_LEN))
    else $error("match progress out of range");

  a_nest_only_when_skipping: assert property (@(posedge clk) disable iff (rst)
    !skipping |-> nest_count == '0)
    else $error("nesting count held outside a dropped list");

  a_pending_not_skipping: assert property (@(posedge clk) disable iff (rst)
    skipping |-> !list_pending)
    else $error("list pending while skipping");

  a_last_clears_state: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> match_progress == '0 && !list_pending && !skipping
                       && nest_count == '0)
    else $error("state not cleared after final character");
`endif

endmodule

### hdl/silc_fifo.sv
// Four-entry result queue that takes up to two results per cycle and gives one.
// Absorbs the two-character "N)" burst; depends on silc_pkg.
module silc_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  silc_pkg::step_out_t  step,
  input  logic                 pop,
  output logic                 room,
  output logic                 not_empty,
  output silc_pkg::out_item_t  head
);

  silc_pkg::out_item_t mem [silc_pkg::FIFO_DEPTH];

  logic [silc_pkg::FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [silc_pkg::FIFO_PTR_W-1:0] wr_ptr_inc;
  logic [silc_pkg::FIFO_CNT_W-1:0] count, count_next;
  logic [1:0]                      wr_count;

  assign wr_count   = push ? step.count : 2'd0;
  assign wr_ptr_inc = wr_ptr + silc_pkg::FIFO_PTR_W'(1);
  assign not_empty  = (count != '0);
  assign head       = mem[rd_ptr];
  // Room for a full burst, decided from registered state only.
  assign room       = (count <= silc_pkg::FIFO_CNT_W'(silc_pkg::FIFO_DEPTH - 2));

  always_comb begin
    count_next = count + silc_pkg::FIFO_CNT_W'(wr_count);
    if (pop) begin
      count_next = count_next - silc_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      mem[wr_ptr] <= step.res0;
    end
    if (wr_count == 2'd2) begin
      mem[wr_ptr_inc] <= step.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + silc_pkg::FIFO_PTR_W'(wr_count);
      if (pop) begin
        rd_ptr <= rd_ptr + silc_pkg::FIFO_PTR_W'(1);
      end
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= silc_pkg::FIFO_CNT_W'(silc_pkg::FIFO_DEPTH))
    else $error("result queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_count != 2'd0 |->
      count <= silc_pkg::FIFO_CNT_W'(silc_pkg::FIFO_DEPTH) - silc_pkg::FIFO_CNT_W'(wr_count))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("result queue underflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    wr_ptr - rd_ptr == count[silc_pkg::FIFO_PTR_W-1:0])
    else $error("result queue pointers disagree with count");
`endif

endmodule

### hdl/sql_in_list_collapser_unit.sv
// Top level of the SQL IN-list collapser: rewrite step feeding a result queue.
// Depends on silc_pkg, silc_step and silc_fifo.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_item  (in_char, in_last)
//   out      output     out_valid/out_ready  out_item (out_char, out_last)
//
// One input character is taken per cycle while in_ready is high; its results are written into a
// four-entry queue at the same edge and can leave from the next cycle on.
// A character yields zero, one or two results, so the output side sets the
// sustained rate: one result per cycle leaves the queue while out_ready is high.
// in_ready is low while the queue holds three or more results.
// Reset is synchronous and clears the matcher state and the queue.
module sql_in_list_collapser_unit #(
  parameter int NEST_WIDTH = silc_pkg::NEST_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  silc_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output silc_pkg::out_item_t  out_item
);

  logic                accept;
  logic                pop;
  silc_pkg::step_out_t step;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;

  silc_step #(
    .NEST_WIDTH(NEST_WIDTH)
  ) u_step (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_item),
    .result (step)
  );

  silc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .step      (step),
    .pop       (pop),
    .room      (in_ready),
    .not_empty (out_valid),
    .head      (out_item)
  );

endmodule

### bench/silc_checker.sv
// Result checker for the SQL IN-list collapser: predicts each rewritten character
// from the accepted input transactions and compares the output transactions in order.
// Depends on silc_pkg for the payload types and character codes.
module silc_checker #(
  parameter int NEST_WIDTH = silc_pkg::NEST_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  silc_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  silc_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending,
  output int                  items_taken,
  output int                  results_checked,
  output int                  lists_collapsed,
  output int                  depth_saturated
);

  localparam logic [39:0] IN_PATTERN = {silc_pkg::CH_SPACE, silc_pkg::CH_I,
                                        silc_pkg::CH_LOWER_N, silc_pkg::CH_SPACE,
                                        silc_pkg::CH_OPEN};

  logic [2:0]            match_pos;
  logic                  list_armed;
  logic                  in_list;
  logic [NEST_WIDTH-1:0] depth;
  silc_pkg::out_item_t   expected_text[$];
  silc_pkg::out_item_t   want_item;

  task automatic flag_error(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("ERROR at result %0d: %s is %02h, expected %02h", results_checked, what, got, want);
    fail_count++;
  endtask

  // Computes the characters that one input character turns into and queues them.
  task automatic rewrite_char(input silc_pkg::in_item_t it);
    silc_pkg::out_item_t res [0:1];
    int                  n;
    int                  p;
    logic [7:0]          c;
    n = 0;
    c = it.in_char;
    if (in_list) begin
      if (c == silc_pkg::CH_OPEN) begin
        if (depth != {NEST_WIDTH{1'b1}}) depth++;
        else depth_saturated++;
      end else if (c == silc_pkg::CH_CLOSE) begin
        if (depth == '0) begin
          in_list = 1'b0;
          res[0] = '{silc_pkg::CH_N, 1'b0};
          res[1] = '{silc_pkg::CH_CLOSE, 1'b0};
          n = 2;
        end else begin
          depth--;
        end
      end
      if (it.in_last && in_list) begin
        res[0] = '{silc_pkg::CH_N, 1'b0};
        res[1] = '{silc_pkg::CH_CLOSE, 1'b0};
        n = 2;
      end
    end else if (list_armed && c == silc_pkg::CH_ANY_MARK) begin
      list_armed = 1'b0;
      in_list = 1'b1;
      depth = '0;
      lists_collapsed++;
      if (it.in_last) begin
        res[0] = '{silc_pkg::CH_N, 1'b0};
        res[1] = '{silc_pkg::CH_CLOSE, 1'b0};
        n = 2;
      end
    end else begin
      list_armed = 1'b0;
      res[0] = '{c, 1'b0};
      n = 1;
      // A mismatch restarts the search, but a space may already begin a new match.
      p = match_pos;
      if (p >= silc_pkg::PATTERN_LEN) p = 0;
      if (c == IN_PATTERN[39 - 8 * p -: 8]) begin
        p++;
        if (p == silc_pkg::PATTERN_LEN) begin
          list_armed = 1'b1;
          p = 0;
        end
      end else begin
        p = (c == silc_pkg::CH_SPACE) ? 1 : 0;
      end
      match_pos = p[2:0];
    end
    if (it.in_last) begin
      if (n > 0) res[n - 1].out_last = 1'b1;
      match_pos = '0;
      list_armed = 1'b0;
      in_list = 1'b0;
      depth = '0;
    end
    for (int i = 0; i < n; i++) expected_text.push_back(res[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      match_pos = '0;
      list_armed = 1'b0;
      in_list = 1'b0;
      depth = '0;
      expected_text.delete();
      fail_count = 0;
      items_taken = 0;
      results_checked = 0;
      lists_collapsed = 0;
      depth_saturated = 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          flag_error("out_char with nothing expected", out_item.out_char, 8'h00);
        end else begin
          want_item = expected_text.pop_front();
          if (out_item.out_char !== want_item.out_char)
            flag_error("out_char", out_item.out_char, want_item.out_char);
          if (out_item.out_last !== want_item.out_last)
            flag_error("out_last", {7'b0, out_item.out_last}, {7'b0, want_item.out_last});
        end
        results_checked++;
      end
      if (in_valid && in_ready) begin
        items_taken++;
        rewrite_char(in_item);
      end
      pending <= expected_text.size();
    end
  end

endmodule

### bench/tb.sv
// Testbench top for sql_in_list_collapser_unit: clock, reset, character stimulus
// and output back-pressure; results are checked by silc_checker beside the block.
// Depends on silc_pkg, silc_checker and the collapser RTL.
module tb;

  // A narrow nesting counter lets random lists reach saturation.
  localparam int NEST_W       = 3;
  localparam int TOTAL_ITEMS  = 1175;
  localparam int HOLD_AT      = 300;
  localparam int QUIET_AFTER  = 1000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  silc_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  silc_pkg::out_item_t out_item;

  int fail_count;
  int pending;
  int items_taken;
  int results_checked;
  int lists_collapsed;
  int depth_saturated;

  int         items_sent = 0;
  int         cycles = 0;
  bit         idle_on = 1'b1;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;
  logic [7:0] query_text[$];

  sql_in_list_collapser_unit #(.NEST_WIDTH(NEST_W)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  silc_checker #(.NEST_WIDTH(NEST_W)) rewrite_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .fail_count      (fail_count),
    .pending         (pending),
    .items_taken     (items_taken),
    .results_checked (results_checked),
    .lists_collapsed (lists_collapsed),
    .depth_saturated (depth_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = silc_pkg::CH_SPACE;
      1:       c = silc_pkg::CH_I;
      2:       c = silc_pkg::CH_LOWER_N;
      3:       c = silc_pkg::CH_OPEN;
      4:       c = silc_pkg::CH_CLOSE;
      5:       c = silc_pkg::CH_ANY_MARK;
      6, 7:    c = 8'($urandom_range(1, 255));
      default: c = 8'($urandom_range(8'h61, 8'h7A));
    endcase
    return c;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{in_char: c, in_last: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_string(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], last && (i == s.len() - 1));
  endtask

  // Builds one query: mostly text around " in (" patterns followed by a '?' list,
  // with broken patterns, deep nesting, lists cut off by the end, and plain noise.
  task automatic build_query();
    int    kind;
    int    open_count;
    int    drop_at;
    bit    deep;
    string pat;
    pat = " in (";
    query_text.delete();
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      repeat ($urandom_range(1, 20)) query_text.push_back(pick_char());
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(0, 5)) query_text.push_back(pick_char());
      drop_at = (kind == 1) ? $urandom_range(0, 4) : silc_pkg::PATTERN_LEN;
      for (int i = 0; i < silc_pkg::PATTERN_LEN; i++)
        query_text.push_back((i == drop_at) ? pick_char() : pat[i]);
      if ($urandom_range(0, 3) == 0) begin
        query_text.push_back(pick_char());
      end else begin
        query_text.push_back(silc_pkg::CH_ANY_MARK);
        open_count = 0;
        deep = ($urandom_range(0, 7) == 0);
        repeat ($urandom_range(0, deep ? 20 : 6)) begin
          case ($urandom_range(0, 5))
            0, 1: begin
              if (deep || $urandom_range(0, 1) == 0) begin
                query_text.push_back(silc_pkg::CH_OPEN);
                open_count++;
              end else begin
                query_text.push_back(",");
              end
            end
            2: begin
              if (open_count > 0) begin
                query_text.push_back(silc_pkg::CH_CLOSE);
                open_count--;
              end else begin
                query_text.push_back(silc_pkg::CH_ANY_MARK);
              end
            end
            3:       query_text.push_back(silc_pkg::CH_SPACE);
            4:       query_text.push_back(8'h30 + 8'($urandom_range(0, 9)));
            default: query_text.push_back(pick_char());
          endcase
        end
        // Sometimes the query ends while the list is still open.
        if ($urandom_range(0, 7) == 0) return;
        repeat (open_count + 1) query_text.push_back(silc_pkg::CH_CLOSE);
      end
    end
    repeat ($urandom_range(0, 4)) query_text.push_back(pick_char());
    if (query_text.size() == 0) query_text.push_back(pick_char());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_string(" in (?(?))", 1'b1);
    send_string(" in (x", 1'b1);
    send_string(" in (?", 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(8'h01, 1'b1);
    while (items_sent < TOTAL_ITEMS) begin
      build_query();
      foreach (query_text[i]) begin
        if (items_sent >= HOLD_AT) hold_req = 1'b1;
        if (items_sent >= QUIET_AFTER) idle_on = 1'b0;
        send_char(query_text[i], i == query_text.size() - 1);
      end
    end
    in_valid <= 1'b0;
    // Let the checker's pending count take in the final transaction before waiting for it.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d characters in queries, checked %0d rewritten characters,",
             items_taken, results_checked);
    $display("%0d lists collapsed; nesting count saturated %0d times; long stall done: %0d.",
             lists_collapsed, depth_saturated, hold_done);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Output side: random stall bursts, plus one long stall that lets the block fill up.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout: run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### sql_in_list_collapser_unit.f
hdl/silc_pkg.sv
hdl/silc_step.sv
hdl/silc_fifo.sv
hdl/sql_in_list_collapser_unit.sv
bench/silc_checker.sv
bench/tb.sv
